// File: hw/rtl/dlbfs_pkg.sv
// Package for the depth-limited breadth-first reach counter.
// Holds operation codes and the controller/datapath command and status structs.
package dlbfs_pkg;

   // Input operation codes.
   localparam logic OP_ADD_EDGE = 1'b0;
   localparam logic OP_QUERY    = 1'b1;

   localparam int FIELD_W = 8;
   localparam int LEVEL_W = 4;
   localparam int COUNT_W = 8;
   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 4'd3;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'hFF;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;    // capture the accepted transaction
      logic write_edge;   // read-modify-write of one adjacency row, first step
      logic commit_edge;  // write the modified row back
      logic clear_step;   // clear one visited bit and advance the sweep index
      logic start_walk;   // mark the start visited and enqueue it
      logic pop;          // read the queue head entry
      logic fetch_row;    // read the adjacency row of the popped user
      logic scan_load;    // latch the row that was read
      logic scan_step;    // examine one neighbour
      logic emit;         // copy the count into the result register
   } dlbfs_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_query;
      logic start_valid;
      logic sweep_done;
      logic queue_empty;
      logic scan_done;
   } dlbfs_sts_type;

endpackage

// File: hw/rtl/dlbfs_if.sv
// Valid/ready channel interfaces for the reach counter.
// Depends on nothing but the fixed field widths.
interface dlbfs_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] followed_user;
   logic [7:0] follower_user;
   modport source (output valid, output op, output followed_user, output follower_user,
                   input ready);
   modport sink (input valid, input op, input followed_user, input follower_user,
                 output ready);
endinterface

interface dlbfs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] reach_count;
   modport source (output valid, output reach_count, input ready);
   modport sink (input valid, input reach_count, output ready);
endinterface

// File: hw/rtl/dlbfs_ctrl.sv
// Controller state machine of the reach counter.
// Uses dlbfs_pkg for the command and status structs.
module dlbfs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output dlbfs_pkg::dlbfs_cmd_type cmd,
   input  dlbfs_pkg::dlbfs_sts_type sts
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_EDGE_RD, ST_EDGE_WR, ST_CLEAR, ST_START,
      ST_POP, ST_FETCH, ST_LOAD, ST_SCAN, ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // A new transaction is taken whenever the walk engine is idle; a waiting
   // result sits in its own register.
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.is_query) state_in = ST_CLEAR;
            else begin
               cmd.write_edge = 1'b1;
               state_in       = ST_EDGE_RD;
            end
         end
         ST_EDGE_RD: state_in = ST_EDGE_WR;
         ST_EDGE_WR: begin
            cmd.commit_edge = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.sweep_done) state_in = ST_START;
         end
         ST_START: begin
            if (sts.start_valid) begin
               cmd.start_walk = 1'b1;
               state_in       = ST_POP;
            end else state_in = ST_DONE;
         end
         ST_POP: begin
            if (sts.queue_empty) state_in = ST_DONE;
            else begin
               cmd.pop  = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch_row = 1'b1;
            state_in      = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.scan_load = 1'b1;
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) state_in = ST_POP;
         end
         ST_DONE: begin
            // Wait until the result register is free or being emptied.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hw/rtl/dlbfs_datapath.sv
// Datapath of the reach counter: adjacency memory, visited map, walk queue, counter.
// Uses dlbfs_pkg; driven by dlbfs_ctrl through command and status structs.
module dlbfs_datapath #(
   parameter int NODES = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_op,
   input  logic [7:0]              in_followed_user,
   input  logic [7:0]              in_follower_user,
   input  logic [3:0]              max_level,
   output logic [7:0]              reach_count,
   input  dlbfs_pkg::dlbfs_cmd_type cmd,
   output dlbfs_pkg::dlbfs_sts_type sts
);

   localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int CNT_W = $clog2(NODES + 1);

   // Adjacency rows; a row that was never written reads as empty through its valid bit.
   logic [NODES-1:0] adj_mem [NODES];
   logic [NODES-1:0] row_valid_ff;
   logic [NODES-1:0] row_rd_ff;
   logic             row_rd_valid_ff;

   // Walk queue memory of node and level.
   logic [IDX_W-1:0] q_node_mem [NODES];
   logic [3:0]       q_level_mem [NODES];

   logic [NODES-1:0] visited_ff;
   logic             op_ff;
   logic [7:0]       a_ff;
   logic [7:0]       b_ff;
   logic [CNT_W-1:0] head_ff;
   logic [CNT_W-1:0] tail_ff;
   logic [IDX_W-1:0] sweep_ff;
   logic [CNT_W-1:0] scan_ff;
   logic [7:0]       count_ff;
   logic [7:0]       rsp_count_ff;
   logic [IDX_W-1:0] cur_node_ff;
   logic [3:0]       cur_level_ff;
   logic [NODES-1:0] row_ff;
   logic [3:0]       limit;
   logic [IDX_W-1:0] scan_idx;
   logic [3:0]       next_level;
   logic             hit;

   assign limit      = (max_level == 4'd0) ? 4'd1 : max_level;
   assign scan_idx   = scan_ff[IDX_W-1:0];
   assign next_level = cur_level_ff + 4'd1;
   assign hit        = row_ff[scan_idx] && !visited_ff[scan_idx];

   assign sts.is_query    = (op_ff == dlbfs_pkg::OP_QUERY);
   assign sts.start_valid = ({24'd0, a_ff} < NODES);
   assign sts.sweep_done  = ({{(32-IDX_W){1'b0}}, sweep_ff} == NODES - 1);
   assign sts.queue_empty = (head_ff == tail_ff);
   assign sts.scan_done   = ({{(32-CNT_W){1'b0}}, scan_ff} == NODES - 1);
   assign reach_count     = rsp_count_ff;

   // Transaction capture.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff <= in_op;
         a_ff  <= in_followed_user;
         b_ff  <= in_follower_user;
      end
   end

   // Adjacency memory: registered read, written whole row at a time.
   always_ff @(posedge clock) begin
      if (cmd.write_edge)     row_rd_ff <= adj_mem[a_ff[IDX_W-1:0]];
      else if (cmd.fetch_row) row_rd_ff <= adj_mem[cur_node_ff];
      if (cmd.commit_edge && {24'd0, a_ff} < NODES && {24'd0, b_ff} < NODES) begin
         adj_mem[a_ff[IDX_W-1:0]] <= (row_valid_ff[a_ff[IDX_W-1:0]] ? row_rd_ff : '0)
                                     | (NODES'(1) << b_ff[IDX_W-1:0]);
      end
   end

   // Row valid bits: a row never written reads as empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff    <= '0;
         row_rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.fetch_row) row_rd_valid_ff <= row_valid_ff[cur_node_ff];
         if (cmd.commit_edge && {24'd0, a_ff} < NODES && {24'd0, b_ff} < NODES)
            row_valid_ff[a_ff[IDX_W-1:0]] <= 1'b1;
      end
   end

   // Walk control: visited sweep, queue pointers, neighbour scan and counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff   <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         sweep_ff     <= '0;
         scan_ff      <= '0;
         count_ff     <= '0;
         rsp_count_ff <= '0;
      end else begin
         if (cmd.load_item) begin
            sweep_ff <= '0;
            head_ff  <= '0;
            tail_ff  <= '0;
            count_ff <= '0;
         end
         if (cmd.clear_step) begin
            visited_ff[sweep_ff] <= 1'b0;
            sweep_ff             <= sweep_ff + 1'b1;
         end
         if (cmd.start_walk) begin
            visited_ff[a_ff[IDX_W-1:0]] <= 1'b1;
            tail_ff                     <= tail_ff + 1'b1;
         end
         if (cmd.pop) head_ff <= head_ff + 1'b1;
         if (cmd.scan_load) scan_ff <= '0;
         if (cmd.scan_step) begin
            scan_ff <= scan_ff + 1'b1;
            if (hit) begin
               visited_ff[scan_idx] <= 1'b1;
               if (next_level < limit && {{(32-CNT_W){1'b0}}, tail_ff} < NODES)
                  tail_ff <= tail_ff + 1'b1;
               if (count_ff != dlbfs_pkg::COUNT_MAX) count_ff <= count_ff + 8'd1;
            end
         end
         // The finished count moves to the result register.
         if (cmd.emit) rsp_count_ff <= count_ff;
      end
   end

   // Queue memory writes and head entry capture.
   always_ff @(posedge clock) begin
      if (cmd.start_walk) begin
         q_node_mem[tail_ff[IDX_W-1:0]]  <= a_ff[IDX_W-1:0];
         q_level_mem[tail_ff[IDX_W-1:0]] <= 4'd0;
      end else if (cmd.scan_step && hit && next_level < limit
                   && {{(32-CNT_W){1'b0}}, tail_ff} < NODES) begin
         q_node_mem[tail_ff[IDX_W-1:0]]  <= scan_idx;
         q_level_mem[tail_ff[IDX_W-1:0]] <= next_level;
      end
      if (cmd.pop) begin
         cur_node_ff  <= q_node_mem[head_ff[IDX_W-1:0]];
         cur_level_ff <= q_level_mem[head_ff[IDX_W-1:0]];
      end
      if (cmd.scan_load) row_ff <= row_rd_valid_ff ? row_rd_ff : '0;
   end

endmodule

// File: hw/rtl/depth_limited_bfs_reach_count.sv
// Depth-limited breadth-first reach counter. An edge load passes through decode,
// a row read and a row write-back after the accepting cycle. A query clears the
// visited map bit by bit, then handles each expanded user with a pop, a row fetch,
// a row latch and a scan of one neighbour a cycle; the single adjacency memory
// read port and the neighbour scan over every node set how long it lasts. The
// count sits in its own result register, so the next transaction can be taken
// while it waits; a finished walk waits for that register to be free.
module depth_limited_bfs_reach_count #(
   parameter int NODES = 256
) (
   input  logic        clock,
   input  logic        reset,
   dlbfs_req_if.sink   req,
   dlbfs_rsp_if.source rsp,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata
);

   dlbfs_pkg::dlbfs_cmd_type cmd;
   dlbfs_pkg::dlbfs_sts_type sts;
   logic [3:0]               max_level_ff;

   // Level limit register.
   always_ff @(posedge clock) begin
      if (reset) max_level_ff <= dlbfs_pkg::LEVEL_RESET;
      else if (csr_we) max_level_ff <= csr_wdata;
   end

   dlbfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   dlbfs_datapath #(.NODES(NODES)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .in_op            (req.op),
      .in_followed_user (req.followed_user),
      .in_follower_user (req.follower_user),
      .max_level        (max_level_ff),
      .reach_count      (rsp.reach_count),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

// File: hw/rtl/dlbfs_checker.sv
// Port-level checker for the reach counter, bound to the top level.
// Depends only on the top level's ports.
module dlbfs_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [7:0] rsp_reach_count
);

   // A result held back stays stable.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reach_count))
      else $error("result changed while stalled");

   // The block is busy in the cycle after it takes a transaction.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready straight after a transaction");

   // A transaction cannot produce a result in the very next cycle.
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared too early");

endmodule

bind depth_limited_bfs_reach_count dlbfs_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_reach_count (rsp.reach_count)
);
